@@ hdl/tgdt_pkg.sv @@
// Shared types and constants for the tile grid dirty tracker.
// Used by tgdt_mem and tile_grid_dirty_tracker; depends on nothing.
package tgdt_pkg;

    localparam int MAX_COLS  = 32;
    localparam int MAX_ROWS  = 32;
    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int COORD_W   = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int DIM_W     = 6;
    localparam int DATA_W    = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        FN_GET   = 3'd0,
        FN_SET   = 3'd1,
        FN_SYNC  = 3'd2,
        FN_NEXT  = 3'd3,
        FN_INVAL = 3'd4,
        FN_CLEAR = 3'd5,
        FN_FILL  = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACC_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic              cell_we;
        logic [DATA_W-1:0] cell_wdata;
        logic              dirty_we;
        logic              dirty_wdata;
    } mem_req_t;

endpackage

@@ hdl/tgdt_mem.sv @@
// Cell value store and dirty bit store, one write and one registered read each.
// Depends on tgdt_pkg.
module tgdt_mem
    import tgdt_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] cell_rdata,
    output logic              dirty_rdata
);

    logic [DATA_W-1:0] cell_ram [CELLS];
    logic              dirty_ram [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.cell_we)
        begin
            cell_ram[req.wr_addr] <= req.cell_wdata;
        end
        cell_rdata <= cell_ram[req.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.dirty_we)
        begin
            dirty_ram[req.wr_addr] <= req.dirty_wdata;
        end
        dirty_rdata <= dirty_ram[req.rd_addr];
    end

endmodule

@@ hdl/tile_grid_dirty_tracker.sv @@
// Top level of the tile grid dirty tracker: sequencer, geometry registers, counters.
// Depends on tgdt_pkg and tgdt_mem.
//
// A command beat is taken when start is high and busy is low; its one result
// beat appears on the result ports for exactly one cycle with done high, and
// the receiver cannot stall it. Get, set and sync do one memory read, then
// set and sync compare and write back and get returns what was read; a
// coordinate outside the grid or a sync index at or past the cell count
// answers from idle with no memory read. Invalidate, clear and fill sweep
// the whole store one cell a cycle. Next dirty walks cells from index 0,
// stepping an index counter and the coordinate counters together, with a
// memory read and then a test for each cell, and ends at the first dirty
// cell at or past the start position or at the cell count. After reset a
// clearing pass zeroes the dirty map with busy high; geometry writes are
// taken at any time, but are meant for idle periods only.
module tile_grid_dirty_tracker
    import tgdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          func,
    input  logic [7:0]          col_x,
    input  logic [7:0]          row_y,
    input  logic [CNT_W-1:0]    linear_pos,
    input  logic [DATA_W-1:0]   cell_data,
    output logic                done,
    output logic                ok,
    output logic [DATA_W-1:0]   read_value,
    output logic                read_dirty,
    output logic [COORD_W-1:0]  found_x,
    output logic [ROW_W-1:0]    found_y,
    output logic [CNT_W-1:0]    cursor_out,
    output logic [CNT_W-1:0]    dirty_total_out,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_W-1:0]    cfg_data
);

    localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELLS - 1);

    state_t              state_reg, state_next;
    func_t               func_reg, func_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [COORD_W-1:0]  sx_reg, sx_next;
    logic [ROW_W-1:0]    sy_reg, sy_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [DIM_W-1:0]    width_reg, height_reg;

    logic                done_reg, done_next;
    logic                ok_reg, ok_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                dbit_reg, dbit_next;
    logic [COORD_W-1:0]  fx_reg, fx_next;
    logic [ROW_W-1:0]    fy_reg, fy_next;
    logic [CNT_W-1:0]    cur_reg, cur_next;

    mem_req_t            req;
    logic [DATA_W-1:0]   cell_rdata;
    logic                dirty_rdata;

    logic [CNT_W-1:0]    active_cells;
    logic                in_bounds;
    logic [CNT_W-1:0]    coord_idx;
    logic                in_grid;

    // Active cell count; at most MAX_COLS * MAX_ROWS, so it fits.
    assign active_cells = CNT_W'(width_reg * height_reg);
    assign in_bounds    = (col_x < {2'b00, width_reg})
                       && (row_y < {2'b00, height_reg});
    assign coord_idx    = CNT_W'(row_y[ROW_W-1:0] * width_reg) + CNT_W'(col_x[COORD_W-1:0]);
    assign in_grid      = idx_reg < active_cells;

    tgdt_mem u_mem (
        .clk         (clk),
        .req         (req),
        .cell_rdata  (cell_rdata),
        .dirty_rdata (dirty_rdata)
    );

    // Geometry registers; drop out-of-range writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH && cfg_data != '0 && cfg_data <= DIM_W'(MAX_COLS))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_HEIGHT && cfg_data != '0 && cfg_data <= DIM_W'(MAX_ROWS))
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        data_reg <= data_next;
        pos_reg  <= pos_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        ok_reg   <= ok_next;
        val_reg  <= val_next;
        dbit_reg <= dbit_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        cur_reg  <= cur_next;
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        total_next = total_reg;
        done_next  = 1'b0;
        ok_next    = 1'b0;
        val_next   = '0;
        dbit_next  = 1'b0;
        fx_next    = '0;
        fy_next    = '0;
        cur_next   = '0;

        req             = '0;
        req.rd_addr     = idx_reg[ADDR_W-1:0];
        req.wr_addr     = idx_reg[ADDR_W-1:0];
        req.cell_wdata  = data_reg;

        case (state_reg)
            ST_INIT:
            begin
                // Clearing pass: zero every dirty bit after reset.
                req.dirty_we    = 1'b1;
                req.dirty_wdata = 1'b0;
                if (idx_reg == LAST_CELL)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func_t'(func);
                    data_next = cell_data;
                    pos_next  = linear_pos;
                    idx_next  = '0;
                    sx_next   = '0;
                    sy_next   = '0;
                    case (func_t'(func))
                        FN_GET, FN_SET:
                        begin
                            if (in_bounds)
                            begin
                                idx_next    = coord_idx;
                                req.rd_addr = coord_idx[ADDR_W-1:0];
                                state_next  = ST_ACC_CHK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        FN_SYNC:
                        begin
                            if (linear_pos < active_cells)
                            begin
                                idx_next    = linear_pos;
                                req.rd_addr = linear_pos[ADDR_W-1:0];
                                state_next  = ST_ACC_CHK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        FN_NEXT:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        FN_INVAL, FN_CLEAR, FN_FILL:
                        begin
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            // Unused code: answer zeros.
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_ACC_CHK:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (func_reg == FN_GET)
                begin
                    ok_next   = 1'b1;
                    val_next  = cell_rdata;
                    dbit_next = dirty_rdata;
                end
                else if (cell_rdata != data_reg)
                begin
                    ok_next     = 1'b1;
                    req.cell_we = 1'b1;
                    if (!dirty_rdata)
                    begin
                        req.dirty_we    = 1'b1;
                        req.dirty_wdata = 1'b1;
                        total_next      = total_reg + 1'b1;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                if (!in_grid)
                begin
                    done_next  = 1'b1;
                    cur_next   = active_cells;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                if (idx_reg >= pos_reg && dirty_rdata)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    val_next   = cell_rdata;
                    fx_next    = sx_reg;
                    fy_next    = sy_reg;
                    cur_next   = idx_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Advance index and coordinates together.
                    idx_next = idx_reg + 1'b1;
                    if ({1'b0, sx_reg} + 1'b1 == width_reg)
                    begin
                        sx_next = '0;
                        sy_next = sy_reg + 1'b1;
                    end
                    else
                    begin
                        sx_next = sx_reg + 1'b1;
                    end
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SWEEP:
            begin
                req.dirty_we    = 1'b1;
                req.dirty_wdata = (func_reg != FN_CLEAR) && in_grid;
                req.cell_we     = (func_reg == FN_FILL) && in_grid;
                if (idx_reg == LAST_CELL)
                begin
                    total_next = (func_reg == FN_CLEAR) ? '0 : active_cells;
                    idx_next   = '0;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign ok              = ok_reg;
    assign read_value      = val_reg;
    assign read_dirty      = dbit_reg;
    assign found_x         = fx_reg;
    assign found_y         = fy_reg;
    assign cursor_out      = cur_reg;
    // Total register already holds the post-operation count during the strobe.
    assign dirty_total_out = total_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command beat left the block idle without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer is busy");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(CELLS))
        else $error("dirty count beyond store depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CHK) |-> (idx_reg < active_cells))
        else $error("scan tested a cell outside the grid");

endmodule
